// File: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Short forms for the concurrent checks used in the RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must hold at every edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

// trig implies cond in the same cycle
`define ASSERT_IMPL(label, clk, rst_n, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error("assertion failed");

// trig implies cond in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("assertion failed");

`endif

// File: rtl/pnq_pkg.sv
// ---------------------------------------------------------------------------
// pnq_pkg
// Shared types, codes and helpers of the pixel normalize block.
// ---------------------------------------------------------------------------
package pnq_pkg;

    localparam int NUM_CH    = 3;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_MEAN0  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MEAN1  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MEAN2  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE0 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE1 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE2 = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_FORMAT = 3'd6;

    localparam logic [31:0] F32_ONE      = 32'h3F80_0000;
    localparam logic [31:0] F32_QNAN_DEF = 32'hFFC0_0000;
    localparam logic [31:0] F32_QUIET    = 32'h0040_0000;

    typedef enum logic [1:0] {
        FMT_FP32  = 2'd0,
        FMT_FP16  = 2'd1,
        FMT_INT8  = 2'd2,
        FMT_UINT8 = 2'd3
    } pnq_fmt_t;

    // per-stage load enables, front to back
    typedef struct packed {
        logic ld;
        logic align;
        logic norm;
        logic rnd;
        logic mul;
        logic mnorm;
        logic mrnd;
        logic enc;
    } pnq_adv_t;

    function automatic logic [4:0] lzc28(input logic [27:0] x);
        logic [4:0] n;
        n = 5'd28;
        for (int i = 0; i < 28; i++)
            if (x[i])
                n = 5'(27 - i);
        return n;
    endfunction

    function automatic logic [5:0] lzc48(input logic [47:0] x);
        logic [5:0] n;
        n = 6'd48;
        for (int i = 0; i < 48; i++)
            if (x[i])
                n = 6'(47 - i);
        return n;
    endfunction

endpackage

// File: rtl/pnq_fadd.sv
// ---------------------------------------------------------------------------
// pnq_fadd
// Sample to float, then sample - mean in float32, RNE. Four stages.
// ---------------------------------------------------------------------------
module pnq_fadd (
    input  logic              clk,
    input  pnq_pkg::pnq_adv_t adv,
    input  logic [7:0]        sample,
    input  logic [31:0]       mean,
    output logic [31:0]       diff
);
    import pnq_pkg::*;

    // stage ld
    logic [31:0] x_reg, y_reg;
    logic [3:0]  lz8;
    logic [7:0]  smp_sh;
    logic [31:0] x_next;

    always_comb
    begin
        lz8 = 4'd8;
        for (int i = 0; i < 8; i++)
            if (sample[i])
                lz8 = 4'(7 - i);
        smp_sh = sample << lz8[2:0];
        if (sample == 8'd0)
            x_next = 32'd0;
        else
            x_next = {1'b0, 8'd134 - {4'd0, lz8}, smp_sh[6:0], 16'd0};
    end

    always_ff @(posedge clk)
    begin
        if (adv.ld)
        begin
            x_reg <= x_next;
            y_reg <= mean ^ 32'h8000_0000;
        end
    end

    // stage align
    logic        x_big;
    logic [31:0] big, sml;
    logic [7:0]  e_b, e_s, dexp;
    logic [23:0] m_b, m_s;
    logic [26:0] ext_s, sh_s, al_next;
    logic        lost;
    logic        spec_next;
    logic [31:0] spec_val_next;

    logic [26:0] a_big_reg, a_small_reg;
    logic [7:0]  a_exp_reg;
    logic        a_sign_reg, a_sub_reg, a_spec_reg;
    logic [31:0] a_spec_val_reg;

    always_comb
    begin
        x_big = x_reg[30:0] >= y_reg[30:0];
        big   = x_big ? x_reg : y_reg;
        sml   = x_big ? y_reg : x_reg;
        e_b   = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
        e_s   = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
        m_b   = {|big[30:23], big[22:0]};
        m_s   = {|sml[30:23], sml[22:0]};
        dexp  = e_b - e_s;
        ext_s = {m_s, 3'b000};
        sh_s  = ext_s >> dexp[4:0];
        lost  = |(ext_s & ~({27{1'b1}} << dexp[4:0]));
        if (dexp >= 8'd27)
            al_next = {26'd0, |m_s};
        else
            al_next = {sh_s[26:1], sh_s[0] | lost};
        // mean NaN keeps its own sign; mean infinity gives the negated infinity
        spec_next = y_reg[30:23] == 8'hFF;
        if (y_reg[22:0] != 23'd0)
            spec_val_next = {~y_reg[31], y_reg[30:0]} | F32_QUIET;
        else
            spec_val_next = y_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv.align)
        begin
            a_big_reg      <= {m_b, 3'b000};
            a_small_reg    <= al_next;
            a_exp_reg      <= e_b;
            a_sign_reg     <= big[31];
            a_sub_reg      <= big[31] ^ sml[31];
            a_spec_reg     <= spec_next;
            a_spec_val_reg <= spec_val_next;
        end
    end

    // stage norm
    logic [27:0] sum;
    logic [4:0]  lz, sh;
    logic [7:0]  lim;
    logic [26:0] nm_next, nm_sh;
    logic [8:0]  ne_next;

    logic [26:0] n_mant_reg;
    logic [8:0]  n_exp_reg;
    logic        n_sign_reg, n_spec_reg;
    logic [31:0] n_spec_val_reg;

    always_comb
    begin
        if (a_sub_reg)
            sum = {1'b0, a_big_reg} - {1'b0, a_small_reg};
        else
            sum = {1'b0, a_big_reg} + {1'b0, a_small_reg};
        lz    = lzc28(sum) - 5'd1;
        lim   = a_exp_reg - 8'd1;
        sh    = ({3'd0, lz} > lim) ? lim[4:0] : lz;
        nm_sh = sum[26:0] << sh;
        if (sum[27])
        begin
            nm_next = {sum[27:2], sum[1] | sum[0]};
            ne_next = {1'b0, a_exp_reg} + 9'd1;
        end
        else
        begin
            nm_next = nm_sh;
            ne_next = nm_sh[26] ? ({1'b0, a_exp_reg} - {4'd0, sh}) : 9'd0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv.norm)
        begin
            n_mant_reg     <= nm_next;
            n_exp_reg      <= ne_next;
            n_sign_reg     <= (sum == 28'd0) ? 1'b0 : a_sign_reg;
            n_spec_reg     <= a_spec_reg;
            n_spec_val_reg <= a_spec_val_reg;
        end
    end

    // stage rnd
    logic        inc;
    logic [31:0] d_next, diff_reg;

    always_comb
    begin
        inc = n_mant_reg[2] & (n_mant_reg[1] | n_mant_reg[0] | n_mant_reg[3]);
        if (n_spec_reg)
            d_next = n_spec_val_reg;
        else if (n_exp_reg >= 9'd255)
            d_next = {n_sign_reg, 8'hFF, 23'd0};
        else
            d_next = {n_sign_reg, {n_exp_reg[7:0], n_mant_reg[25:3]} + {30'd0, inc}};
    end

    always_ff @(posedge clk)
    begin
        if (adv.rnd)
            diff_reg <= d_next;
    end

    assign diff = diff_reg;

endmodule

// File: rtl/pnq_fmul.sv
// ---------------------------------------------------------------------------
// pnq_fmul
// float32 multiply, RNE with subnormals. Three stages.
// ---------------------------------------------------------------------------
module pnq_fmul (
    input  logic              clk,
    input  pnq_pkg::pnq_adv_t adv,
    input  logic [31:0]       a,
    input  logic [31:0]       b,
    output logic [31:0]       prod
);
    import pnq_pkg::*;

    // stage mul
    logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, sg;
    logic [23:0] ma, mb;
    logic [7:0]  ea, eb;
    logic        spec_next;
    logic [31:0] spec_val_next;

    logic [47:0]        p_reg;
    logic signed [10:0] esum_reg;
    logic               p_sign_reg, p_spec_reg;
    logic [31:0]        p_spec_val_reg;

    always_comb
    begin
        a_nan  = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
        b_nan  = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
        a_inf  = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
        b_inf  = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
        a_zero = a[30:0] == 31'd0;
        b_zero = b[30:0] == 31'd0;
        sg     = a[31] ^ b[31];
        ea     = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
        eb     = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
        ma     = {|a[30:23], a[22:0]};
        mb     = {|b[30:23], b[22:0]};
        spec_next = a_nan | b_nan | a_inf | b_inf | a_zero | b_zero;
        if (a_nan)
            spec_val_next = a | F32_QUIET;
        else if (b_nan)
            spec_val_next = b | F32_QUIET;
        else if ((a_inf & b_zero) | (a_zero & b_inf))
            spec_val_next = F32_QNAN_DEF;
        else if (a_inf | b_inf)
            spec_val_next = {sg, 8'hFF, 23'd0};
        else
            spec_val_next = {sg, 31'd0};
    end

    always_ff @(posedge clk)
    begin
        if (adv.mul)
        begin
            p_reg          <= ma * mb;
            esum_reg       <= $signed({3'd0, ea}) + $signed({3'd0, eb}) - 11'sd126;
            p_sign_reg     <= sg;
            p_spec_reg     <= spec_next;
            p_spec_val_reg <= spec_val_next;
        end
    end

    // stage mnorm: leading one to bit 47
    logic [5:0]         lz;
    logic [47:0]        n_reg;
    logic signed [10:0] e_reg;
    logic               n_sign_reg, n_spec_reg;
    logic [31:0]        n_spec_val_reg;

    assign lz = lzc48(p_reg);

    always_ff @(posedge clk)
    begin
        if (adv.mnorm)
        begin
            n_reg          <= p_reg << lz;
            e_reg          <= esum_reg - $signed({5'd0, lz});
            n_sign_reg     <= p_sign_reg;
            n_spec_reg     <= p_spec_reg;
            n_spec_val_reg <= p_spec_val_reg;
        end
    end

    // stage mrnd: denormalize if needed, round
    logic signed [10:0] rsh;
    logic [47:0]        shd;
    logic               st_x, inc;
    logic [7:0]         ex;
    logic [31:0]        r_next, prod_reg;

    always_comb
    begin
        rsh  = 11'sd1 - e_reg;
        shd  = n_reg;
        st_x = 1'b0;
        ex   = e_reg[7:0];
        if (e_reg <= 11'sd0)
        begin
            ex = 8'd0;
            if (rsh >= 11'sd48)
            begin
                shd  = 48'd0;
                st_x = |n_reg;
            end
            else
            begin
                shd  = n_reg >> rsh[5:0];
                st_x = |(n_reg & ~({48{1'b1}} << rsh[5:0]));
            end
        end
        inc = shd[23] & ((|shd[22:0]) | st_x | shd[24]);
        if (n_spec_reg)
            r_next = n_spec_val_reg;
        else if (e_reg >= 11'sd255)
            r_next = {n_sign_reg, 8'hFF, 23'd0};
        else
            r_next = {n_sign_reg, {ex, shd[46:24]} + {30'd0, inc}};
    end

    always_ff @(posedge clk)
    begin
        if (adv.mrnd)
            prod_reg <= r_next;
    end

    assign prod = prod_reg;

endmodule

// File: rtl/pnq_encode.sv
// ---------------------------------------------------------------------------
// pnq_encode
// Output encoding of one channel: fp32, fp16, int8 or uint8. One stage.
// ---------------------------------------------------------------------------
module pnq_encode (
    input  logic               clk,
    input  pnq_pkg::pnq_adv_t  adv,
    input  pnq_pkg::pnq_fmt_t  fmt,
    input  logic [31:0]        r,
    output logic [31:0]        value
);
    import pnq_pkg::*;

    logic [7:0]        e8;
    logic [22:0]       man;
    logic signed [9:0] he;
    logic [4:0]        hsh;
    logic [23:0]       hm, hm_r;
    logic [15:0]       half;
    logic [23:0]       mr;
    logic              nan, neg, sat;
    logic [4:0]        ish;
    logic [8:0]        q, n;
    logic [7:0]        i8, u8;
    logic [31:0]       v_next, value_reg;

    always_comb
    begin
        e8  = r[30:23];
        man = r[22:0];
        neg = r[31];

        // fp16: half-ulp add then truncate
        he   = $signed({2'd0, e8}) - 10'sd112;
        hsh  = 5'(10'sd1 - he);
        hm   = {1'b1, man} >> hsh;
        hm_r = hm + 24'h00_1000;
        mr   = {1'b0, man} + 24'h00_1000;
        if (he <= 10'sd0)
        begin
            if (he < -10'sd10)
                half = {neg, 15'd0};
            else
                half = {neg, 4'd0, hm_r[23:13]};
        end
        else if (he >= 10'sd31)
            half = {neg, 15'h7C00};
        else
            half = {neg, {he[4:0], 10'd0} + {4'd0, mr[23:13]}};

        // integer: floor(2|r|) + 1 >> 1 rounds half away from zero
        nan = (e8 == 8'hFF) && (man != 23'd0);
        sat = e8 >= 8'd135;
        ish = 5'(8'd149 - e8);
        q   = 9'(({1'b1, man}) >> ish);
        n   = (e8 < 8'd126) ? 9'd0 : 9'(({1'b0, q} + 10'd1) >> 1);

        if (nan)
            i8 = 8'd0;
        else if (neg)
            i8 = (sat || n >= 9'd128) ? 8'h80 : 8'(-n);
        else
            i8 = (sat || n >= 9'd127) ? 8'h7F : n[7:0];

        if (nan || neg)
            u8 = 8'd0;
        else
            u8 = (sat || n >= 9'd255) ? 8'hFF : n[7:0];

        case (fmt)
            FMT_FP32: v_next = r;
            FMT_FP16: v_next = {16'd0, half};
            FMT_INT8: v_next = {24'd0, i8};
            default:  v_next = {24'd0, u8};
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv.enc)
            value_reg <= v_next;
    end

    assign value = value_reg;

endmodule

// File: rtl/pixel_normalize_quantize.sv
// ---------------------------------------------------------------------------
// pixel_normalize_quantize
// Per-channel (sample - mean) * scale of RGB888 pixels, float32 RNE,
// encoded as fp32, fp16, int8 or uint8.
// ---------------------------------------------------------------------------
// One pixel per cycle in and out while the output is not stalled; the pipe has
// four float add stages, three float multiply stages and the encode/output
// register. Every stage holds its own valid bit, so empty stages fill while
// the output stalls. Write configuration only while no pixel is in flight.
`include "assert_macros.svh"

module pixel_normalize_quantize (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [23:0]                     s_tdata,   // red, green, blue
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [95:0]                     m_tdata,   // value_ch0, value_ch1, value_ch2
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [pnq_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [31:0]                     cfg_data
);
    import pnq_pkg::*;

    localparam int NSTG = 8;

    // configuration
    logic [31:0] mean_reg  [NUM_CH];
    logic [31:0] scale_reg [NUM_CH];
    pnq_fmt_t    fmt_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < NUM_CH; c++)
            begin
                mean_reg[c]  <= 32'd0;
                scale_reg[c] <= F32_ONE;
            end
            fmt_reg <= FMT_FP32;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_MEAN0:  mean_reg[0]  <= cfg_data;
                CFG_MEAN1:  mean_reg[1]  <= cfg_data;
                CFG_MEAN2:  mean_reg[2]  <= cfg_data;
                CFG_SCALE0: scale_reg[0] <= cfg_data;
                CFG_SCALE1: scale_reg[1] <= cfg_data;
                CFG_SCALE2: scale_reg[2] <= cfg_data;
                CFG_FORMAT: fmt_reg      <= pnq_fmt_t'(cfg_data[1:0]);
                default: ;
            endcase
        end
    end

    // stage valids; a stage loads when it is empty or its successor loads
    logic [NSTG-1:0] vld_reg, vld_next;
    logic [NSTG:0]   rdy;

    always_comb
    begin
        rdy[NSTG] = m_tready;
        for (int i = NSTG - 1; i >= 0; i--)
            rdy[i] = !vld_reg[i] || rdy[i+1];
        vld_next = vld_reg;
        if (rdy[0])
            vld_next[0] = s_tvalid;
        for (int i = 1; i < NSTG; i++)
            if (rdy[i])
                vld_next[i] = vld_reg[i-1];
    end

    pnq_adv_t adv_map;
    assign adv_map.ld    = rdy[0];
    assign adv_map.align = rdy[1];
    assign adv_map.norm  = rdy[2];
    assign adv_map.rnd   = rdy[3];
    assign adv_map.mul   = rdy[4];
    assign adv_map.mnorm = rdy[5];
    assign adv_map.mrnd  = rdy[6];
    assign adv_map.enc   = rdy[7];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    assign s_tready = rdy[0];
    assign m_tvalid = vld_reg[NSTG-1];

    // datapath, one lane per channel
    for (genvar c = 0; c < NUM_CH; c++)
    begin : g_ch
        logic [31:0] diff, prod, value;

        pnq_fadd u_fadd (
            .clk    (clk),
            .adv    (adv_map),
            .sample (s_tdata[8*c +: 8]),
            .mean   (mean_reg[c]),
            .diff   (diff)
        );

        pnq_fmul u_fmul (
            .clk  (clk),
            .adv  (adv_map),
            .a    (diff),
            .b    (scale_reg[c]),
            .prod (prod)
        );

        pnq_encode u_enc (
            .clk   (clk),
            .adv   (adv_map),
            .fmt   (fmt_reg),
            .r     (prod),
            .value (value)
        );

        assign m_tdata[32*c +: 32] = value;
    end

    // a stage with a waiting request keeps it while the next stage is blocked
    `ASSERT_NEXT(a_hold_mid, clk, rst_n, vld_reg[3] && !rdy[4], vld_reg[3])
    // an empty front stage always takes a request
    `ASSERT_IMPL(a_front_open, clk, rst_n, !vld_reg[0], s_tready)
    // a full pipe with a stalled output takes nothing
    `ASSERT_IMPL(a_full_stall, clk, rst_n, (&vld_reg) && !m_tready, !s_tready)

endmodule
